/* hw/rtl/rstm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rstm_pkg;

  localparam int RingDepth = 32;
  localparam int SlotW = $clog2(RingDepth);
  localparam int CountW = $clog2(RingDepth + 1);
  localparam int SumW = 16 + SlotW + 8;
  localparam logic [16:0] AgeMax = 17'h1FFFF;
  localparam logic [15:0] EmptyLatest = 16'hFFFF;

  localparam logic [1:0] ActTick = 2'd0;
  localparam logic [1:0] ActReading = 2'd1;
  localparam logic [1:0] ActQuery = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StStale = 3'd1;
  localparam logic [2:0] StBadMin = 3'd2;
  localparam logic [2:0] StBadFrac = 3'd3;
  localparam logic [2:0] StTooFew = 3'd4;
  localparam logic [2:0] StNoneKept = 3'd5;

  localparam logic [1:0] RegAgeLimit = 2'd0;
  localparam logic [1:0] RegTrim = 2'd1;
  localparam logic [1:0] RegMinRd = 2'd2;
  localparam logic [1:0] RegMaxRd = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] range_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] mean_q8;
    logic [5:0]  used_count;
    logic [15:0] latest_value;
    logic [16:0] age_ms;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the query and pick status
    logic copy;      // copy one ring entry into scratch
    logic sort_step; // one compare-exchange step
    logic sum_step;  // add one kept entry
    logic div_init;  // start the divider
    logic div_step;  // one quotient bit
    logic emit;      // drive result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic do_filter;  // checks passed
    logic copy_done;
    logic sort_done;
    logic sum_done;
    logic div_done;
    logic none_kept;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/rstm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module rstm_datapath
  import rstm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic [15:0] cfg_addr_data,
  input  wire logic [1:0] cfg_index,
  input  wire logic      accept,
  input  wire in_item_t  item,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output out_item_t      res
);

  logic [15:0] age_limit;
  logic [8:0]  trim_q8;
  logic [5:0]  min_rd;
  logic [5:0]  max_rd;

  logic [15:0] ring [RingDepth];
  logic [15:0] scratch [RingDepth];
  logic [SlotW-1:0] wslot;
  logic [CountW-1:0] fill;
  logic [16:0] since;

  logic [SlotW-1:0] idx;      // copy / sum index
  logic [SlotW-1:0] pass_i;   // odd-even sort pass counter
  logic [CountW-1:0] used;
  logic [CountW-1:0] drop;
  logic [CountW-1:0] kept;
  logic [SumW-1:0] rem;
  logic [23:0] quo;
  logic [4:0]  qbit;
  logic [2:0]  st;
  logic [15:0] latest;
  logic [16:0] age_q;
  logic        odd_phase;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= 16'd1000;
      trim_q8 <= 9'd128;
      min_rd <= 6'd1;
      max_rd <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        RegAgeLimit: age_limit <= cfg_addr_data;
        RegTrim: trim_q8 <= cfg_addr_data[8:0];
        RegMinRd: min_rd <= cfg_addr_data[5:0];
        RegMaxRd: max_rd <= cfg_addr_data[5:0];
        default: ;
      endcase
    end
  end

  // Ring pointer, fill level and age counter.
  logic flush;
  logic [SlotW-1:0] wr_slot;
  assign flush = since > {1'b0, age_limit};
  assign wr_slot = flush ? '0 : wslot;
  always_ff @(posedge clk) begin
    if (rst) begin
      wslot <= '0;
      fill <= '0;
      since <= AgeMax;
    end else if (accept) begin
      case (item.action)
        ActTick: if (since != AgeMax) since <= since + 17'd1;
        ActReading: begin
          since <= '0;
          wslot <= wr_slot + 1'b1;
          if (flush) fill <= CountW'(1);
          else if (fill != CountW'(RingDepth)) fill <= fill + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Ring store and registered copy read.
  logic [15:0] ring_rd;
  logic [SlotW-1:0] rd_slot;
  assign rd_slot = wslot - SlotW'(1) - idx;
  always_ff @(posedge clk) begin
    if (accept && item.action == ActReading) ring[wr_slot] <= item.range_value;
    ring_rd <= ring[rd_slot];
  end

  // Query: status checks and derived counts.
  logic [CountW-1:0] used_c;
  logic [CountW+8:0] share;
  logic [CountW-1:0] drop_c;
  logic [2:0] st_c;
  always_comb begin
    used_c = ({1'b0, max_rd} > 7'(fill)) ? fill : CountW'(max_rd);
    share = (CountW+9)'(used_c) * (CountW+9)'(trim_q8);
    drop_c = CountW'((share[CountW+8:8] + 1'b1) >> 1);
    if (since >= {1'b0, age_limit}) st_c = StStale;
    else if (min_rd == 6'd0) st_c = StBadMin;
    else if (trim_q8 > 9'd256) st_c = StBadFrac;
    else if (7'(fill) < {1'b0, min_rd}) st_c = StTooFew;
    else st_c = StOk;
  end

  // Copy, odd-even transposition sort, sum and restoring division.
  // The first sort cycle only lets the last copied entry land in scratch.
  logic copy_v;
  logic [SlotW-1:0] copy_idx;
  always_ff @(posedge clk) begin
    copy_v <= cmd.copy;
    copy_idx <= idx;
    if (copy_v) scratch[copy_idx] <= ring_rd;
    if (cmd.sort_step && !copy_v) begin
      for (int k = 0; k < RingDepth - 1; k++) begin
        if ((k[0] == odd_phase) && (CountW'(k + 1) < used) &&
            (scratch[k] > scratch[k+1])) begin
          scratch[k] <= scratch[k+1];
          scratch[k+1] <= scratch[k];
        end
      end
    end
  end

  logic [SumW-1:0] trial;
  assign trial = {rem[SumW-2:0], quo[23]} - SumW'(kept);
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; pass_i <= '0; odd_phase <= 1'b0;
    end else begin
      if (cmd.load) begin
        st <= st_c;
        latest <= (fill != '0) ? ring[wslot - SlotW'(1)] : EmptyLatest;
        age_q <= since;
        used <= (st_c == StOk) ? used_c : '0;
        drop <= drop_c;
        kept <= used_c - (drop_c << 1);
        idx <= '0;
        pass_i <= '0;
        odd_phase <= 1'b0;
        rem <= '0;
      end
      if (cmd.copy) idx <= idx + 1'b1;
      if (cmd.sort_step) begin
        idx <= SlotW'(drop);
        if (!copy_v) begin
          odd_phase <= ~odd_phase;
          pass_i <= pass_i + 1'b1;
        end
      end
      if (cmd.sum_step) begin
        rem <= rem + SumW'(scratch[idx]);
        idx <= idx + 1'b1;
      end
      if (cmd.div_init) begin
        quo <= 24'(rem << 8);
        rem <= SumW'(rem >> 16);
        qbit <= '0;
      end
      if (cmd.div_step) begin
        qbit <= qbit + 1'b1;
        if (!trial[SumW-1]) begin
          rem <= trial;
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= {rem[SumW-2:0], quo[23]};
          quo <= {quo[22:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    stat.do_filter = (st == StOk);
    stat.copy_done = (CountW'(idx) + 1'b1 >= used) || (used == '0);
    stat.sort_done = (pass_i == SlotW'(RingDepth - 1));
    stat.sum_done = (CountW'(idx) + 1'b1 >= used - drop);
    stat.div_done = (qbit == 5'd23);
    stat.none_kept = ((drop << 1) >= used);
    res.status = (st == StOk && stat.none_kept) ? StNoneKept : st;
    res.mean_q8 = (st == StOk && !stat.none_kept) ? quo : 24'd0;
    res.used_count = 6'(used);
    res.latest_value = latest;
    res.age_ms = age_q;
  end

endmodule
`default_nettype wire

/* hw/rtl/rstm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module rstm_ctrl
  import rstm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic [1:0] action,
  input  wire dp_stat_t stat,
  output logic          busy,
  output logic          done,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_COPY, S_SORT, S_SUM, S_DIVI, S_DIV, S_EMIT
  } state_t;
  state_t state;

  // Sequencer for one query.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start && action == ActQuery) begin
          state <= S_LOAD; busy <= 1'b1;
        end
        S_LOAD: state <= stat.do_filter ? S_COPY : S_EMIT;
        S_COPY: if (stat.copy_done) state <= S_SORT;
        S_SORT: if (stat.sort_done) state <= stat.none_kept ? S_EMIT : S_SUM;
        S_SUM: if (stat.sum_done) state <= S_DIVI;
        S_DIVI: state <= S_DIV;
        S_DIV: if (stat.div_done) state <= S_EMIT;
        S_EMIT: begin
          state <= S_IDLE; busy <= 1'b0; done <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && start && action == ActQuery;
    cmd.copy = (state == S_COPY);
    cmd.sort_step = (state == S_SORT);
    cmd.sum_step = (state == S_SUM);
    cmd.div_init = (state == S_DIVI);
    cmd.div_step = (state == S_DIV);
    cmd.emit = (state == S_EMIT);
  end

  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EMIT)) else $error("done without emit");
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy) else $error("busy in idle");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.copy, cmd.sort_step, cmd.sum_step, cmd.div_step}))
    else $error("command overlap");

endmodule
`default_nettype wire

/* hw/rtl/range_sample_trimmed_mean_filter.sv */
// A tick or reading takes effect at its transfer edge. A filtered query steps through load,
// copy, sort, sum, divider start, divide and emit before done; an error status through
// load and emit only; a query with nothing kept through load, copy, sort and emit.
// Throughput: one query at a time; busy drops with done, so the next item can transfer then.
// The result strobe done is high for one cycle; the receiver cannot stall.
// Reset (rst, synchronous): ring empty, age saturated (stale), registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
module range_sample_trimmed_mean_filter
  import rstm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           done,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic accept;
  assign accept = start && !busy;

  rstm_ctrl u_ctrl (
    .clk, .rst, .start(accept), .action(in_item.action), .stat, .busy, .done, .cmd
  );

  rstm_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_addr_data(cfg_data), .cfg_index, .accept,
    .item(in_item), .cmd, .stat, .res(out_item)
  );

endmodule
`default_nettype wire

/* dv/range_sample_trimmed_mean_filter_tb.sv */
`timescale 1ns / 1ps
module range_sample_trimmed_mean_filter_tb;
  import rstm_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t in_item;
  logic done;
  out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  range_sample_trimmed_mean_filter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the filter state and its settings.
  logic [15:0] age_limit;
  logic [8:0] trim_q8;
  logic [5:0] min_rd;
  logic [5:0] max_rd;
  logic [15:0] ring [RingDepth];
  logic [4:0] wr_slot;
  logic [5:0] fill;
  logic [16:0] age;

  out_item_t pending_results[$];
  int mismatches;
  int hard_errors;

  typedef struct {
    logic [1:0] act;
    logic [15:0] value;
    logic has_expect;
    logic [2:0] exp_status;
    logic [5:0] exp_used;
    logic [15:0] exp_latest;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("range_sample_trimmed_mean_filter test failed");
    $finish;
  end

  // Apply one accepted item to the shadow state; queue a result for queries.
  task automatic filter_apply(input in_item_t it);
    logic [15:0] vals [RingDepth];
    logic [15:0] tmp;
    logic [5:0] used;
    logic [5:0] share;
    logic [5:0] drop;
    logic [31:0] sum;
    out_item_t res;
    int i;
    int j;
    if (it.action == ActTick) begin
      if (age != AgeMax) age++;
    end else if (it.action == ActReading) begin
      if (age > {1'b0, age_limit}) begin
        wr_slot = '0;
        fill = '0;
      end
      age = '0;
      ring[wr_slot] = it.range_value;
      wr_slot = wr_slot + 5'd1;
      if (fill < RingDepth) fill++;
    end else if (it.action == ActQuery) begin
      res = '0;
      res.latest_value = (fill != 0) ? ring[wr_slot - 5'd1] : EmptyLatest;
      res.age_ms = age;
      if (age >= {1'b0, age_limit}) res.status = StStale;
      else if (min_rd == 0) res.status = StBadMin;
      else if (trim_q8 > 9'd256) res.status = StBadFrac;
      else if (fill < min_rd) res.status = StTooFew;
      else begin
        used = (max_rd > fill) ? fill : max_rd;
        res.used_count = used;
        for (i = 0; i < used; i++) vals[i] = ring[wr_slot - 5'd1 - 5'(i)];
        for (i = 1; i < used; i++) begin
          for (j = i; j > 0 && vals[j - 1] > vals[j]; j--) begin
            tmp = vals[j];
            vals[j] = vals[j - 1];
            vals[j - 1] = tmp;
          end
        end
        share = 6'((32'(used) * 32'(trim_q8)) >> 8);
        drop = 6'((32'(share) + 1) >> 1);
        if (2 * 32'(drop) >= 32'(used)) res.status = StNoneKept;
        else begin
          sum = 0;
          for (i = drop; i < used - drop; i++) sum += vals[i];
          res.mean_q8 = 24'((sum << 8) / (32'(used) - 2 * 32'(drop)));
        end
      end
      pending_results.push_back(res);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    start <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegAgeLimit: age_limit = val;
      RegTrim: trim_q8 = val[8:0];
      RegMinRd: min_rd = val[5:0];
      default: max_rd = val[5:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one item and wait for its transfer; start stays high for a follow-on item.
  task automatic send_item(input logic [1:0] act, input logic [15:0] val, input int gap);
    in_item_t it;
    it.action = act;
    it.range_value = val;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    filter_apply(it);
  endtask

  // Wait until every query has answered, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        hard_errors++;
        $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, out_item);
        end
      end
    end
  end

  function automatic logic [1:0] rand_action();
    int r;
    r = $urandom_range(99);
    if (r < 45) return ActTick;
    if (r < 75) return ActReading;
    if (r < 97) return ActQuery;
    return 2'd3;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1000, 1100));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(255));
    endcase
  endfunction

  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    int k;
    int phase;
    mismatches = 0;
    hard_errors = 0;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    age_limit = 16'd1000;
    trim_q8 = 9'd128;
    min_rd = 6'd1;
    max_rd = 6'd32;
    wr_slot = '0;
    fill = '0;
    age = AgeMax;
    for (k = 0; k < RingDepth; k++) ring[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: after reset, a tick at the saturated age, extremes, the unknown action.
    rows = '{
      '{ActTick, 16'h0, 1'b0, 3'd0, 6'd0, 16'd0},
      '{ActQuery, 16'h0, 1'b1, StStale, 6'd0, EmptyLatest},
      '{ActReading, 16'hFFFF, 1'b0, 3'd0, 6'd0, 16'd0},
      '{ActQuery, 16'h0, 1'b1, StOk, 6'd1, 16'hFFFF},
      '{ActReading, 16'h0000, 1'b0, 3'd0, 6'd0, 16'd0},
      '{ActReading, 16'h5A5A, 1'b0, 3'd0, 6'd0, 16'd0},
      '{2'd3, 16'hA5A5, 1'b0, 3'd0, 6'd0, 16'd0},
      '{ActTick, 16'h0, 1'b0, 3'd0, 6'd0, 16'd0},
      '{ActQuery, 16'h0, 1'b0, 3'd0, 6'd0, 16'd0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.act, r.value, 0);
      if (r.has_expect && pending_results.size() != 0) begin
        if (pending_results[$].status !== r.exp_status ||
            pending_results[$].used_count !== r.exp_used ||
            pending_results[$].latest_value !== r.exp_latest) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %0d/%0d/%h actual %0d/%0d/%h", i,
                     r.exp_status, r.exp_used, r.exp_latest,
                     pending_results[$].status, pending_results[$].used_count,
                     pending_results[$].latest_value);
        end
      end
    end
    // Fill past the ring depth, then query at the default trim, at full trim and under bad settings.
    for (k = 0; k < 40; k++) send_item(ActReading, 16'(k * 1637), 0);
    send_item(ActQuery, 16'h0, 0);
    drain();
    write_reg(RegTrim, 16'd256);
    send_item(ActQuery, 16'h0, 0);
    drain();
    write_reg(RegTrim, 16'd257);
    send_item(ActQuery, 16'h0, 0);
    drain();
    write_reg(RegTrim, 16'd0);
    write_reg(RegMinRd, 16'd0);
    send_item(ActQuery, 16'h0, 0);
    drain();
    write_reg(RegMinRd, 16'd33);
    send_item(ActQuery, 16'h0, 0);
    drain();
    write_reg(RegMinRd, 16'd1);
    write_reg(RegMaxRd, 16'd0);
    send_item(ActQuery, 16'h0, 0);
    drain();
    write_reg(RegAgeLimit, 16'd0);
    send_item(ActQuery, 16'h0, 0);
    drain();

    // Random phases, each under its own settings.
    for (phase = 0; phase < 10; phase++) begin
      write_reg(RegAgeLimit, (phase == 9) ? 16'hFFFF : 16'($urandom_range(2, 40)));
      write_reg(RegTrim, (phase % 4 == 0) ? 16'($urandom_range(511))
                                          : 16'($urandom_range(256)));
      write_reg(RegMinRd, (phase == 3) ? 16'd0 : 16'($urandom_range(1, 33)));
      write_reg(RegMaxRd, (phase == 5) ? 16'd63 : 16'($urandom_range(32)));
      for (k = 0; k < 190; k++)
        send_item(rand_action(), rand_value(),
                  ($urandom_range(3) == 0) ? 0 : $urandom_range(11));
      drain();
    end
    // Tick run, then one query under the widest age limit.
    for (k = 0; k < 40; k++) send_item(ActTick, 16'($urandom), 0);
    send_item(ActQuery, 16'h0, 0);
    drain();

    if (mismatches == 0 && hard_errors == 0 && pending_results.size() == 0) begin
      $display("range_sample_trimmed_mean_filter test passed");
    end else begin
      $display("range_sample_trimmed_mean_filter test failed");
    end
    $finish;
  end
endmodule
